/* rtl/hrhp_pkg.sv */
// hrhp_pkg: types and constants shared by the HTTP request head parser.
// Holds the transaction structs, the parse state record and the character codes.
// No dependencies.
`default_nettype none

package hrhp_pkg;

    localparam int LENGTH_WIDTH = 31;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    typedef enum logic [2:0] {
        PH_LINE = 3'd0,
        PH_HEAD = 3'd1,
        PH_BODY = 3'd2,
        PH_DONE = 3'd3,
        PH_LERR = 3'd4,
        PH_HERR = 3'd5
    } phase_t;

    // request line steps
    localparam logic [3:0] LS_START    = 4'd0;
    localparam logic [3:0] LS_METHOD   = 4'd1;
    localparam logic [3:0] LS_URL_WAIT = 4'd2;
    localparam logic [3:0] LS_URL      = 4'd3;
    localparam logic [3:0] LS_H        = 4'd4;
    localparam logic [3:0] LS_T1       = 4'd5;
    localparam logic [3:0] LS_T2       = 4'd6;
    localparam logic [3:0] LS_P        = 4'd7;
    localparam logic [3:0] LS_SLASH    = 4'd8;
    localparam logic [3:0] LS_MAJOR    = 4'd9;
    localparam logic [3:0] LS_DOT      = 4'd10;
    localparam logic [3:0] LS_MINOR    = 4'd11;
    localparam logic [3:0] LS_CR       = 4'd12;
    localparam logic [3:0] LS_LF       = 4'd13;

    // header steps
    localparam logic [3:0] HS_START      = 4'd0;
    localparam logic [3:0] HS_KEY        = 4'd1;
    localparam logic [3:0] HS_COLON      = 4'd2;
    localparam logic [3:0] HS_VALUE_WAIT = 4'd3;
    localparam logic [3:0] HS_VALUE      = 4'd4;
    localparam logic [3:0] HS_LF         = 4'd5;
    localparam logic [3:0] HS_NEXT       = 4'd6;
    localparam logic [3:0] HS_END_LF     = 4'd7;

    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_LINE_DONE = 3'd1;
    localparam logic [2:0] ST_HEAD_DONE = 3'd2;
    localparam logic [2:0] ST_COMPLETE  = 3'd3;
    localparam logic [2:0] ST_LINE_ERR  = 3'd4;
    localparam logic [2:0] ST_HEAD_ERR  = 3'd5;
    localparam logic [2:0] ST_IDLE      = 3'd6;

    localparam logic [2:0] CLS_DELIM  = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URL    = 3'd2;
    localparam logic [2:0] CLS_KEY    = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_BODY   = 3'd5;

    localparam logic [1:0] MK_NONE    = 2'd0;
    localparam logic [1:0] MK_GET     = 2'd1;
    localparam logic [1:0] MK_POST    = 2'd2;
    localparam logic [1:0] MK_UNKNOWN = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    // method bytes packed first character lowest
    localparam logic [31:0] WORD_GET  = 32'h0054_4547;
    localparam logic [31:0] WORD_POST = 32'h5453_4F50;

    localparam int CL_LEN = 14;
    localparam logic [3:0] CL_LEN_CODE = 4'd14;
    localparam logic [0:CL_LEN-1][7:0] CL_NAME = "Content-Length";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_request;
    } in_item_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [1:0]              method_code;
        logic [3:0]              version_major;
        logic [3:0]              version_minor;
        logic [2:0]              byte_class;
        logic                    header_complete;
        logic                    is_length_header;
        logic [LENGTH_WIDTH-1:0] content_length;
        logic [LENGTH_WIDTH-1:0] body_received;
    } out_item_t;

    typedef struct packed {
        phase_t                  phase;
        logic [3:0]              sub_state;
        logic [3:0][7:0]         method_chars;
        logic [2:0]              method_len;
        logic [1:0]              method_kind;
        logic [3:0]              major_ver;
        logic [3:0]              minor_ver;
        logic [3:0]              key_match_pos;
        logic                    key_matching;
        logic [LENGTH_WIDTH-1:0] value_accum;
        logic                    value_digits_open;
        logic [LENGTH_WIDTH-1:0] declared_length;
        logic [LENGTH_WIDTH-1:0] body_count;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:             PH_LINE,
        sub_state:         LS_START,
        method_chars:      '0,
        method_len:        3'd0,
        method_kind:       MK_NONE,
        major_ver:         4'd0,
        minor_ver:         4'd0,
        key_match_pos:     4'd0,
        key_matching:      1'b1,
        value_accum:       '0,
        value_digits_open: 1'b1,
        declared_length:   '0,
        body_count:        '0
    };

endpackage

`default_nettype wire

/* rtl/http_request_head_parser.sv */
// http_request_head_parser: top level, parse state register and output buffering.
// Instantiates hrhp_step; depends on hrhp_pkg.
//
// One byte of an HTTP request goes in per cycle while req_ready is high and
// one result comes out for each byte, in order. The whole parse step (request
// line, header lines, Content-Length value, body count) is evaluated
// combinationally against the parse state register, so a byte can be accepted
// on every clock while req_ready is high. Results sit in a two-entry output
// buffer; req_ready drops only when both entries are occupied, so the input
// side keeps running while one result waits for rslt_ready. start_request
// clears the parse state before its own byte.
`default_nettype none

module http_request_head_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire hrhp_pkg::in_item_t req,
    output logic                    rslt_valid,
    input  wire logic               rslt_ready,
    output hrhp_pkg::out_item_t     rslt
);
    import hrhp_pkg::*;

    parse_state_t state_reg;
    parse_state_t cur;
    parse_state_t state_next;
    out_item_t    step_res;
    out_item_t    out_reg;
    out_item_t    skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         req_fire;
    logic         rslt_fire;

    assign req_ready = !skid_valid_reg;
    assign req_fire  = req_valid && req_ready;
    assign rslt_fire = out_valid_reg && rslt_ready;
    assign cur       = req.start_request ? STATE_RESET : state_reg;

    hrhp_step u_step (
        .cur (cur),
        .ch  (req.data_byte),
        .nxt (state_next),
        .res (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
                state_reg <= state_next;
            if (skid_valid_reg)
            begin
                if (rslt_fire)
                    skid_valid_reg <= 1'b0;
            end
            else if (req_fire)
            begin
                if (out_valid_reg && !rslt_ready)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (rslt_fire)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rslt_fire)
                out_reg <= skid_reg;
        end
        else if (req_fire)
        begin
            if (out_valid_reg && !rslt_ready)
                skid_reg <= step_res;
            else
                out_reg <= step_res;
        end
    end

    assign rslt_valid = out_valid_reg;
    assign rslt       = out_reg;

endmodule

`default_nettype wire

/* rtl/hrhp_step.sv */
// hrhp_step: combinational parse step, one byte against the current parse state.
// Gives the next parse state and the result transaction for that byte.
// Depends on hrhp_pkg.
`default_nettype none

module hrhp_step (
    input  wire hrhp_pkg::parse_state_t cur,
    input  wire logic [7:0]             ch,
    output hrhp_pkg::parse_state_t      nxt,
    output hrhp_pkg::out_item_t         res
);
    import hrhp_pkg::*;

    localparam int AW = LENGTH_WIDTH + 4;

    logic       is_upper;
    logic       is_digit;
    logic [4:0] key_first;
    logic [4:0] key_cont;
    logic [LENGTH_WIDTH:0] val_cont;
    logic [LENGTH_WIDTH-1:0] body_inc;
    logic [2:0] status;
    logic [2:0] cls;
    logic       hdone;
    logic       islen;

    // returns {matching, pos}
    function automatic logic [4:0] key_step(input logic [3:0] pos, input logic m,
                                           input logic [7:0] c);
        logic [4:0] r;
        if (m && pos < CL_LEN_CODE && c == CL_NAME[pos])
            r = {1'b1, pos + 4'd1};
        else
            r = {1'b0, pos};
        return r;
    endfunction

    // returns {digits_open, accum}
    function automatic logic [LENGTH_WIDTH:0] value_step(input logic [LENGTH_WIDTH-1:0] acc,
                                                        input logic open,
                                                        input logic [7:0] c);
        logic [AW-1:0] wide;
        logic [LENGTH_WIDTH:0] r;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + AW'(c - CH_0);
        if (open && c >= CH_0 && c <= CH_9)
            r = {1'b1, (wide > {4'b0, LEN_MAX}) ? LEN_MAX : wide[LENGTH_WIDTH-1:0]};
        else
            r = {1'b0, acc};
        return r;
    endfunction

    assign is_upper  = (ch >= CH_UA) && (ch <= CH_UZ);
    assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
    assign key_first = key_step(4'd0, 1'b1, ch);
    assign key_cont  = key_step(cur.key_match_pos, cur.key_matching, ch);
    assign val_cont  = value_step(cur.value_accum, cur.value_digits_open, ch);
    assign body_inc  = (cur.body_count != LEN_MAX) ? cur.body_count + 1'b1 : cur.body_count;

    // next state
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_LINE:
            begin
                case (cur.sub_state)
                    LS_START:
                    begin
                        if (ch == CH_CR || ch == CH_LF)
                            nxt.phase = PH_LINE;
                        else if (!is_upper)
                            nxt.phase = PH_LERR;
                        else
                        begin
                            nxt.method_chars = {24'b0, ch};
                            nxt.method_len   = 3'd1;
                            nxt.sub_state    = LS_METHOD;
                        end
                    end
                    LS_METHOD:
                    begin
                        if (ch == CH_SP)
                        begin
                            if (cur.method_len == 3'd3)
                                nxt.method_kind = (cur.method_chars == WORD_GET) ? MK_GET : MK_NONE;
                            else if (cur.method_len == 3'd4)
                                nxt.method_kind = (cur.method_chars == WORD_POST) ? MK_POST
                                                                                  : MK_NONE;
                            else
                                nxt.method_kind = MK_UNKNOWN;
                            nxt.sub_state = LS_URL_WAIT;
                        end
                        else if (!is_upper)
                            nxt.phase = PH_LERR;
                        else
                        begin
                            if (cur.method_len < 3'd4)
                                nxt.method_chars[cur.method_len[1:0]] = ch;
                            if (cur.method_len != 3'd7)
                                nxt.method_len = cur.method_len + 3'd1;
                        end
                    end
                    LS_URL_WAIT:
                    begin
                        if (ch == CH_SLASH)
                            nxt.sub_state = LS_URL;
                        else if (ch != CH_SP)
                            nxt.phase = PH_LERR;
                    end
                    LS_URL:
                    begin
                        if (ch == CH_SP)
                            nxt.sub_state = LS_H;
                    end
                    LS_H:
                    begin
                        if (ch == CH_H)
                            nxt.sub_state = LS_T1;
                        else if (ch != CH_SP)
                            nxt.phase = PH_LERR;
                    end
                    LS_T1:
                    begin
                        if (ch == CH_T) nxt.sub_state = LS_T2; else nxt.phase = PH_LERR;
                    end
                    LS_T2:
                    begin
                        if (ch == CH_T) nxt.sub_state = LS_P; else nxt.phase = PH_LERR;
                    end
                    LS_P:
                    begin
                        if (ch == CH_P) nxt.sub_state = LS_SLASH; else nxt.phase = PH_LERR;
                    end
                    LS_SLASH:
                    begin
                        if (ch == CH_SLASH) nxt.sub_state = LS_MAJOR; else nxt.phase = PH_LERR;
                    end
                    LS_MAJOR:
                    begin
                        if (ch >= CH_1 && ch <= CH_9)
                        begin
                            nxt.major_ver = ch[3:0];
                            nxt.sub_state = LS_DOT;
                        end
                        else
                            nxt.phase = PH_LERR;
                    end
                    LS_DOT:
                    begin
                        if (ch == CH_DOT) nxt.sub_state = LS_MINOR; else nxt.phase = PH_LERR;
                    end
                    LS_MINOR:
                    begin
                        if (is_digit)
                        begin
                            nxt.minor_ver = ch[3:0];
                            nxt.sub_state = LS_CR;
                        end
                        else
                            nxt.phase = PH_LERR;
                    end
                    LS_CR:
                    begin
                        if (ch == CH_CR) nxt.sub_state = LS_LF; else nxt.phase = PH_LERR;
                    end
                    LS_LF:
                    begin
                        if (ch == CH_LF)
                        begin
                            nxt.phase     = PH_HEAD;
                            nxt.sub_state = HS_START;
                        end
                        else
                            nxt.phase = PH_LERR;
                    end
                    default: nxt.phase = PH_LERR;
                endcase
            end
            PH_HEAD:
            begin
                case (cur.sub_state)
                    HS_START, HS_NEXT:
                    begin
                        if (ch == CH_CR)
                            nxt.sub_state = HS_END_LF;
                        else if (!(cur.sub_state == HS_START && ch == CH_LF))
                        begin
                            nxt.key_matching      = key_first[4];
                            nxt.key_match_pos     = key_first[3:0];
                            nxt.value_accum       = '0;
                            nxt.value_digits_open = 1'b1;
                            nxt.sub_state         = HS_KEY;
                        end
                    end
                    HS_KEY:
                    begin
                        if (ch == CH_SP)
                            nxt.sub_state = HS_COLON;
                        else if (ch == CH_COLON)
                            nxt.sub_state = HS_VALUE_WAIT;
                        else
                        begin
                            nxt.key_matching  = key_cont[4];
                            nxt.key_match_pos = key_cont[3:0];
                        end
                    end
                    HS_COLON:
                    begin
                        if (ch == CH_COLON)
                            nxt.sub_state = HS_VALUE_WAIT;
                        else if (ch != CH_SP)
                            nxt.phase = PH_HERR;
                    end
                    HS_VALUE_WAIT:
                    begin
                        if (ch != CH_SP)
                        begin
                            nxt.value_digits_open = val_cont[LENGTH_WIDTH];
                            nxt.value_accum       = val_cont[LENGTH_WIDTH-1:0];
                            nxt.sub_state         = HS_VALUE;
                        end
                    end
                    HS_VALUE:
                    begin
                        if (ch == CH_CR)
                            nxt.sub_state = HS_LF;
                        else if (ch == CH_LF)
                            nxt.sub_state = HS_NEXT;
                        else
                        begin
                            nxt.value_digits_open = val_cont[LENGTH_WIDTH];
                            nxt.value_accum       = val_cont[LENGTH_WIDTH-1:0];
                        end
                    end
                    HS_LF:
                    begin
                        if (ch != CH_LF)
                            nxt.phase = PH_HERR;
                        else
                        begin
                            if (cur.key_matching && cur.key_match_pos == CL_LEN_CODE)
                                nxt.declared_length = cur.value_accum;
                            nxt.sub_state = HS_NEXT;
                        end
                    end
                    HS_END_LF:
                    begin
                        if (ch != CH_LF)
                            nxt.phase = PH_HERR;
                        else
                        begin
                            nxt.sub_state = HS_START;
                            nxt.phase     = (cur.declared_length == '0) ? PH_DONE : PH_BODY;
                        end
                    end
                    default: nxt.phase = PH_HERR;
                endcase
            end
            PH_BODY:
            begin
                nxt.body_count = body_inc;
                if (body_inc >= cur.declared_length)
                    nxt.phase = PH_DONE;
            end
            default: nxt.phase = cur.phase;
        endcase
    end

    // result flags
    always_comb
    begin
        status = ST_PROGRESS;
        cls    = CLS_DELIM;
        hdone  = 1'b0;
        islen  = 1'b0;
        case (cur.phase)
            PH_LINE:
            begin
                if (nxt.phase == PH_LERR)
                    status = ST_LINE_ERR;
                else
                begin
                    if (cur.sub_state == LS_LF)
                        status = ST_LINE_DONE;
                    if ((cur.sub_state == LS_START && is_upper) ||
                        (cur.sub_state == LS_METHOD && ch != CH_SP))
                        cls = CLS_METHOD;
                    else if ((cur.sub_state == LS_URL_WAIT && ch == CH_SLASH) ||
                             (cur.sub_state == LS_URL && ch != CH_SP))
                        cls = CLS_URL;
                end
            end
            PH_HEAD:
            begin
                if (nxt.phase == PH_HERR)
                    status = ST_HEAD_ERR;
                else
                begin
                    if (cur.sub_state == HS_END_LF)
                        status = ST_HEAD_DONE;
                    if (((cur.sub_state == HS_START || cur.sub_state == HS_NEXT) &&
                         nxt.sub_state == HS_KEY) ||
                        (cur.sub_state == HS_KEY && nxt.sub_state == HS_KEY))
                        cls = CLS_KEY;
                    else if ((cur.sub_state == HS_VALUE_WAIT || cur.sub_state == HS_VALUE) &&
                             nxt.sub_state == HS_VALUE)
                        cls = CLS_VALUE;
                    if (cur.sub_state == HS_LF)
                    begin
                        hdone = 1'b1;
                        islen = cur.key_matching && cur.key_match_pos == CL_LEN_CODE;
                    end
                end
            end
            PH_BODY:
            begin
                cls = CLS_BODY;
                if (nxt.phase == PH_DONE)
                    status = ST_COMPLETE;
            end
            PH_LERR: status = ST_LINE_ERR;
            PH_HERR: status = ST_HEAD_ERR;
            default: status = ST_IDLE;
        endcase
    end

    assign res.status           = status;
    assign res.method_code      = nxt.method_kind;
    assign res.version_major    = nxt.major_ver;
    assign res.version_minor    = nxt.minor_ver;
    assign res.byte_class       = cls;
    assign res.header_complete  = hdone;
    assign res.is_length_header = islen;
    assign res.content_length   = nxt.declared_length;
    assign res.body_received    = nxt.body_count;

endmodule

`default_nettype wire

/* rtl/hrhp_checker.sv */
// hrhp_checker: port-level assertions for http_request_head_parser, with bind.
// Depends on hrhp_pkg.
`default_nettype none

module hrhp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rslt_valid,
    input wire logic                rslt_ready,
    input wire hrhp_pkg::out_item_t rslt
);
    import hrhp_pkg::*;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rslt_valid)
        else $error("accepted byte produced no result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && !rslt_ready |=> rslt_valid && $stable(rslt))
        else $error("stalled result changed or dropped");

    a_length_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt.is_length_header |-> rslt.header_complete)
        else $error("length flag without completed header");

    a_header_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt.header_complete |->
            rslt.status == ST_PROGRESS && rslt.byte_class == CLS_DELIM)
        else $error("completed header with wrong status or class");

    a_codes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid |-> rslt.status <= ST_IDLE && rslt.byte_class <= CLS_BODY)
        else $error("status or byte class out of range");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (.*);

`default_nettype wire
